// File: rtl/core/sst_pkg.sv
// Shared types and constants for the sync sample table block.
// Opcode and status codes, the result record and the default table depth.
// No dependencies.
package sst_pkg;

   // Default number of table entries
   localparam int SST_TABLE_DEPTH = 4096;

   // Fixed field widths of the channels
   localparam int SST_NUM_W   = 32;
   localparam int SST_COUNT_W = 13;

   // Item opcodes
   typedef enum logic [1:0] {
      OP_QUERY  = 2'd0,
      OP_START  = 2'd1,
      OP_OFFSET = 2'd2
   } opcode_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // One result item
   typedef struct packed {
      logic                   is_sync;
      status_type             status;
      logic [SST_COUNT_W-1:0] entry_count;
   } result_type;

endpackage

// File: rtl/core/sst_ram.sv
// Simple dual-port table memory: one write port, one read port.
// Read data is registered. Uses sst_pkg.
module sst_ram
   import sst_pkg::*;
#(
   parameter int TABLE_DEPTH = SST_TABLE_DEPTH,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [SST_NUM_W-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [SST_NUM_W-1:0] rd_data
);

   logic [SST_NUM_W-1:0] mem [TABLE_DEPTH];
   logic [SST_NUM_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sst_ctrl.sv
// Sequencer of the sync sample table: query walk, batch start, prefill and
// batch offsets. Drives the table memory ports. Uses sst_pkg.
module sst_ctrl
   import sst_pkg::*;
#(
   parameter int TABLE_DEPTH = SST_TABLE_DEPTH,
   localparam int AW = $clog2(TABLE_DEPTH),
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   // input item
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_opcode,
   input  logic [SST_NUM_W-1:0]   req_sample_number,
   input  logic [SST_NUM_W-1:0]   req_sample_count,
   input  logic [SST_COUNT_W-1:0] req_offset_count,
   input  logic [SST_NUM_W-1:0]   req_sample_offset,
   // table memory
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [SST_NUM_W-1:0]   wr_data,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   input  logic [SST_NUM_W-1:0]   rd_data,
   // finished result
   output logic                   res_valid,
   input  logic                   res_ready,
   output result_type             res_data
);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_QUERY   = 4'b0010,
      S_PREFILL = 4'b0100,
      S_DONE    = 4'b1000
   } state_type;

   localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

   state_type              state_ff, state_in;
   logic [CW-1:0]          committed_ff, committed_in;
   logic                   prefill_done_ff, prefill_done_in;
   logic [CW-1:0]          wp_ff, wp_in;
   logic [SST_NUM_W-1:0]   base_ff, base_in;
   logic [SST_NUM_W-1:0]   span_ff, span_in;
   logic [SST_COUNT_W-1:0] remaining_ff, remaining_in;
   logic                   failed_ff, failed_in;
   logic [SST_NUM_W-1:0]   qnum_ff, qnum_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic                   pend_ff, pend_in;
   logic [CW-1:0]          fill_end_ff, fill_end_in;
   result_type             res_ff, res_in;

   logic                   accept;
   logic                   prefill_en;
   logic [SST_NUM_W-1:0]   prefill_amt;
   logic [SST_NUM_W+1:0]   needed;
   logic                   hit;
   logic                   larger;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

   // Batch start sizing: prefill only into an empty table still all-sync
   assign prefill_en  = (committed_ff == '0) && !prefill_done_ff;
   assign prefill_amt = prefill_en ? (req_sample_number - SST_NUM_W'(1)) : '0;
   assign needed      = (SST_NUM_W+2)'(committed_ff) + (SST_NUM_W+2)'(prefill_amt)
                        + (SST_NUM_W+2)'(req_offset_count);

   // Query compare against the entry read last cycle
   assign hit    = pend_ff && (rd_data == qnum_ff);
   assign larger = pend_ff && (qnum_ff < rd_data);

   // Next state and datapath
   always_comb begin
      state_in        = state_ff;
      committed_in    = committed_ff;
      prefill_done_in = prefill_done_ff;
      wp_in           = wp_ff;
      base_in         = base_ff;
      span_in         = span_ff;
      remaining_in    = remaining_ff;
      failed_in       = failed_ff;
      qnum_in         = qnum_ff;
      idx_in          = idx_ff;
      pend_in         = 1'b0;
      fill_end_in     = fill_end_ff;
      res_in          = res_ff;
      wr_en           = 1'b0;
      wr_addr         = wp_ff[AW-1:0];
      wr_data         = req_sample_offset;
      rd_en           = 1'b0;
      rd_addr         = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in.is_sync = 1'b0;
               res_in.status  = ST_BAD;
               state_in       = S_DONE;
               unique case (req_opcode)
                  OP_QUERY: begin
                     if (req_sample_number != '0) begin
                        qnum_in  = req_sample_number;
                        idx_in   = '0;
                        state_in = S_QUERY;
                     end
                  end
                  OP_START: begin
                     base_in      = req_sample_number;
                     span_in      = req_sample_count;
                     remaining_in = req_offset_count;
                     failed_in    = 1'b0;
                     wp_in        = committed_ff;
                     if (req_sample_number == '0) begin
                        failed_in = 1'b1;
                     end else begin
                        if (committed_ff == '0) begin
                           prefill_done_in = prefill_done_ff ?
                                             (req_offset_count == '0) : 1'b1;
                        end
                        if (needed > (SST_NUM_W+2)'(TABLE_DEPTH)) begin
                           failed_in     = 1'b1;
                           res_in.status = ST_FULL;
                        end else if (prefill_amt != '0) begin
                           fill_end_in = CW'(prefill_amt);
                           state_in    = S_PREFILL;
                        end else begin
                           res_in.status = ST_OK;
                           if (req_offset_count == '0) begin
                              committed_in = committed_ff;
                           end
                        end
                     end
                  end
                  OP_OFFSET: begin
                     if (remaining_ff != '0) begin
                        remaining_in = remaining_ff - SST_COUNT_W'(1);
                        if (!failed_ff) begin
                           if (req_sample_offset == '0 || req_sample_offset > span_ff) begin
                              failed_in = 1'b1;
                           end else begin
                              res_in.status = ST_OK;
                              wr_en         = (wp_ff < DEPTH_CNT);
                              wr_data       = base_ff + req_sample_offset
                                              - SST_NUM_W'(1);
                              wp_in         = wp_ff + CW'(1);
                           end
                        end
                        // commit a clean batch at its last offset
                        if (remaining_in == '0 && !failed_in) begin
                           committed_in = wp_in;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               res_in.entry_count = SST_COUNT_W'(committed_in);
            end
         end
         S_QUERY: begin
            if (hit || larger) begin
               res_in.is_sync     = hit;
               res_in.status      = ST_OK;
               res_in.entry_count = SST_COUNT_W'(committed_ff);
               state_in           = S_DONE;
            end else if (idx_ff == committed_ff) begin
               res_in.is_sync     = 1'b0;
               res_in.status      = ST_OK;
               res_in.entry_count = SST_COUNT_W'(committed_ff);
               state_in           = S_DONE;
            end else begin
               // fetch the next entry
               rd_en   = 1'b1;
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end
         end
         S_PREFILL: begin
            if (wp_ff != fill_end_ff) begin
               // write entry n-1 as sample number n
               wr_en   = (wp_ff < DEPTH_CNT);
               wr_data = SST_NUM_W'(wp_ff) + SST_NUM_W'(1);
               wp_in   = wp_ff + CW'(1);
            end else begin
               if (remaining_ff == '0) begin
                  committed_in = wp_ff;
               end
               res_in.is_sync     = 1'b0;
               res_in.status      = ST_OK;
               res_in.entry_count = SST_COUNT_W'(committed_in);
               state_in           = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         committed_ff    <= '0;
         prefill_done_ff <= 1'b0;
         wp_ff           <= '0;
         remaining_ff    <= '0;
         failed_ff       <= 1'b0;
         pend_ff         <= 1'b0;
      end else begin
         state_ff        <= state_in;
         committed_ff    <= committed_in;
         prefill_done_ff <= prefill_done_in;
         wp_ff           <= wp_in;
         remaining_ff    <= remaining_in;
         failed_ff       <= failed_in;
         pend_ff         <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      span_ff     <= span_in;
      qnum_ff     <= qnum_in;
      idx_ff      <= idx_in;
      fill_end_ff <= fill_end_in;
      res_ff      <= res_in;
   end

endmodule

// File: rtl/core/sst_rsp.sv
// Result output register of the sync sample table.
// Holds one result until the receiver takes it. Uses sst_pkg.
module sst_rsp
   import sst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   res_valid,
   output logic                   res_ready,
   input  result_type             res_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_sync,
   output logic [1:0]             rsp_status,
   output logic [SST_COUNT_W-1:0] rsp_entry_count
);

   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   assign res_ready = !rsp_valid_ff || rsp_ready;

   // Load a new result when the register is empty or drains this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_sync     = rsp_data_ff.is_sync;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_entry_count = rsp_data_ff.entry_count;

endmodule

// File: rtl/core/sync_sample_table.sv
// Sync sample table: ascending table of sync-sample numbers with query and
// batch append. Every accepted item on the req_ channel gives one result on
// the rsp_ channel, in order. Opcode query asks whether sample_number is a
// sync sample; start opens a batch (base, span, offset count); offset adds one
// entry at base+offset-1. A batch's entries are committed after its last
// offset, and a bad offset or overflow discards the whole batch.
// Work per item, from request transfer to result ready in the output register:
//   offset, reserved opcode, bad query, failed start: no table walk or prefill
//   query: walks entries until a match, a larger entry or the committed count; the walk
//          fetches one entry per cycle from the table memory read port
//   start: prefills entries 1 .. base-1 when it is the first batch;
//          the prefill writes one entry per cycle through the write port
// One item is in work at a time; the next request is taken once the current
// result has moved into the output register, which holds it while the
// receiver stalls. Synchronous reset clears counters and the output valid;
// the table memory is not cleared, since only written entries are read.
// Depends on sst_pkg, sst_ctrl, sst_ram and sst_rsp.
module sync_sample_table
   import sst_pkg::*;
#(
   parameter int TABLE_DEPTH = SST_TABLE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_opcode,
   input  logic [SST_NUM_W-1:0]   req_sample_number,
   input  logic [SST_NUM_W-1:0]   req_sample_count,
   input  logic [SST_COUNT_W-1:0] req_offset_count,
   input  logic [SST_NUM_W-1:0]   req_sample_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_sync,
   output logic [1:0]             rsp_status,
   output logic [SST_COUNT_W-1:0] rsp_entry_count
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [SST_NUM_W-1:0] wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [SST_NUM_W-1:0] rd_data;
   logic                 res_valid;
   logic                 res_ready;
   result_type           res_data;

   // Sequencer
   sst_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_sample_number (req_sample_number),
      .req_sample_count  (req_sample_count),
      .req_offset_count  (req_offset_count),
      .req_sample_offset (req_sample_offset),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res_data          (res_data)
   );

   // Table memory
   sst_ram #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register
   sst_rsp u_rsp (
      .clock           (clock),
      .reset           (reset),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res_data        (res_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_sync     (rsp_is_sync),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// File: rtl/core/sst_checker.sv
// Port-level checks for sync_sample_table, attached by the bind below.
// Sees the top-level ports only. Uses sst_pkg.
module sst_checker
   import sst_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [1:0]             req_opcode,
   input logic [SST_NUM_W-1:0]   req_sample_number,
   input logic [SST_NUM_W-1:0]   req_sample_count,
   input logic [SST_COUNT_W-1:0] req_offset_count,
   input logic [SST_NUM_W-1:0]   req_sample_offset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_is_sync,
   input logic [1:0]             rsp_status,
   input logic [SST_COUNT_W-1:0] rsp_entry_count
);

   // Waiting request holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_opcode)
         && $stable(req_sample_number) && $stable(req_sample_count)
         && $stable(req_offset_count) && $stable(req_sample_offset))
      else $error("waiting request changed");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_sync)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("stalled result changed");

   // A sync answer only comes with an ok status
   a_sync_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_sync |-> rsp_status == ST_OK)
      else $error("sync result without ok status");

   // No result appears right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Status is always one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_BAD
         || rsp_status == ST_FULL)
      else $error("undefined result status");

endmodule

bind sync_sample_table sst_checker u_sst_checker (.*);
